### rtl/agb_pkg.sv
// shared types and constants of the antialiased glyph blitter
package agb_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned NIB_W      = 4;
	localparam int unsigned X_W        = 11;
	localparam int unsigned Y_W        = 9;
	localparam int unsigned COLOR_W    = 15;
	localparam int unsigned CHAN_W     = 5;
	localparam int unsigned CFG_IDX_W  = 4;
	localparam int unsigned CFG_DATA_W = 15;
	localparam int unsigned SIDE_W     = 7;
	localparam int unsigned POS_W      = 12;

	// result queue between the lanes and the output port
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = 2;
	localparam int unsigned QCNT_W      = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PEN_COLOR     = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_X        = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_Y        = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SKIP_X        = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SKIP_Y        = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH   = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT  = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ADVANCE_PITCH = 4'd7;

	// one shaded pixel found by a lane
	typedef struct packed {
		logic                    valid;
		logic signed [X_W-1:0]   x;
		logic [COLOR_W-1:0]      color;
	} agb_pix_t;

	// one pixel write waiting for the output port
	typedef struct packed {
		logic signed [X_W-1:0]   x;
		logic [Y_W-1:0]          y;
		logic [COLOR_W-1:0]      color;
		logic                    last;
	} agb_wr_t;

endpackage

### rtl/agb_glyph_if.sv
// glyph byte channel
interface agb_glyph_if;
	import agb_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] glyph_byte;
	modport source(output valid, output glyph_byte, input ready);
	modport sink(input valid, input glyph_byte, output ready);
endinterface

### rtl/agb_pixel_if.sv
// pixel write channel
interface agb_pixel_if;
	import agb_pkg::*;
	logic                  valid;
	logic                  ready;
	logic signed [X_W-1:0] pixel_x;
	logic [Y_W-1:0]        pixel_y;
	logic [COLOR_W-1:0]    pixel_color;
	logic                  last_write;
	modport source(output valid, output pixel_x, output pixel_y, output pixel_color,
		output last_write, input ready);
	modport sink(input valid, input pixel_x, input pixel_y, input pixel_color,
		input last_write, output ready);
endinterface

### rtl/agb_cfg_if.sv
// configuration write channel
interface agb_cfg_if;
	import agb_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  reg_index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, output reg_index, output data, input ready);
	modport sink(input valid, input reg_index, input data, output ready);
endinterface

### rtl/antialiased_glyph_blitter_unit.sv
// top level of the antialiased 4-bit glyph blitter with RGB555 output
//
// Usage: load the registers on the cfg channel (index 0..7: pen color, cell x,
// cell y, skip x, skip y, glyph width, glyph height, advance pitch) while the
// block is idle; every write also restarts the glyph at row 0, column 0.
// Then stream the glyph's coverage bytes in row order on the glyph channel,
// (width+1)/2 bytes per row, low nibble on the left. Each nonzero nibble of a
// visible row gives one beat on the pixel channel with its screen x, y and
// shaded color; last_write marks the final beat caused by a byte.
// Path: an accepted byte is registered in the byte stage, then written into
// the result queue whose head offers its first write; a queue without room
// holds the byte in the byte stage. Throughput: one byte per cycle while the
// receiver is ready and each byte yields at most one write; a byte with two
// writes uses the single output port once per write, so such bytes stream
// slower. The rate is set by the one pixel port and four-entry result queue.
// The two nibbles are shaded by two parallel lanes; a merge stage orders
// their writes. When the receiver stalls, the queue fills and the glyph
// channel drops ready; nothing is lost. Reset empties the queue and restores
// the register defaults; cfg is always ready.
module antialiased_glyph_blitter_unit #(
	parameter int unsigned SCREEN_WIDTH   = 480,
	parameter int unsigned SCREEN_HEIGHT  = 272,
	parameter int unsigned MAX_GLYPH_SIDE = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	agb_cfg_if.sink       cfg,
	agb_glyph_if.sink     glyph,
	agb_pixel_if.source   pixel
);
	import agb_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_GLYPH_SIDE + 1);
	localparam logic signed [POS_W-1:0] SCR_W = POS_W'(SCREEN_WIDTH);
	localparam logic signed [POS_W-1:0] SCR_H = POS_W'(SCREEN_HEIGHT);
	localparam logic [SIDE_W-1:0]       MAX_SIDE = SIDE_W'(MAX_GLYPH_SIDE);

	// configuration registers
	logic [COLOR_W-1:0]      pen_color_q;
	logic signed [9:0]       cell_x_q;
	logic signed [9:0]       cell_y_q;
	logic [5:0]              skip_x_q;
	logic [5:0]              skip_y_q;
	logic [SIDE_W-1:0]       glyph_width_q;
	logic [SIDE_W-1:0]       glyph_height_q;
	logic [SIDE_W-1:0]       advance_pitch_q;

	// glyph position counters
	logic [CNT_W-1:0]        col_q;
	logic [CNT_W-1:0]        row_q;

	// byte stage
	logic                    valid_s1;
	logic [BYTE_W-1:0]       byte_s1;
	logic signed [X_W-1:0]   x0_s1;
	logic [Y_W-1:0]          y_s1;
	logic                    vis_s1;

	logic                    cfg_wr;
	logic                    take;
	logic                    advance;
	logic [SIDE_W-1:0]       w_eff;
	logic [SIDE_W-1:0]       h_eff;
	logic                    empty_glyph;
	logic                    wrap;
	logic [CNT_W-1:0]        col_eff;
	logic [CNT_W-1:0]        row_eff;
	logic signed [POS_W-1:0] x0_pos;
	logic signed [POS_W-1:0] y_pos;
	logic                    rejected;
	logic                    visible;
	logic                    row_end;
	agb_pix_t                lane_l;
	agb_pix_t                lane_r;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;
	assign glyph.ready = !valid_s1 || advance;
	assign take      = glyph.valid && glyph.ready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_color_q     <= COLOR_W'(32767);
			cell_x_q        <= '0;
			cell_y_q        <= '0;
			skip_x_q        <= '0;
			skip_y_q        <= '0;
			glyph_width_q   <= SIDE_W'(8);
			glyph_height_q  <= SIDE_W'(14);
			advance_pitch_q <= SIDE_W'(8);
		end else if (cfg_wr) begin
			case (cfg.reg_index)
				REG_PEN_COLOR:     pen_color_q     <= cfg.data;
				REG_CELL_X:        cell_x_q        <= cfg.data[9:0];
				REG_CELL_Y:        cell_y_q        <= cfg.data[9:0];
				REG_SKIP_X:        skip_x_q        <= cfg.data[5:0];
				REG_SKIP_Y:        skip_y_q        <= cfg.data[5:0];
				REG_GLYPH_WIDTH:   glyph_width_q   <= cfg.data[SIDE_W-1:0];
				REG_GLYPH_HEIGHT:  glyph_height_q  <= cfg.data[SIDE_W-1:0];
				REG_ADVANCE_PITCH: advance_pitch_q <= cfg.data[SIDE_W-1:0];
				default: ;
			endcase
		end
	end

	// clamped glyph size and effective position
	always_comb begin
		w_eff = (glyph_width_q > MAX_SIDE) ? MAX_SIDE : glyph_width_q;
		h_eff = (glyph_height_q > MAX_SIDE) ? MAX_SIDE : glyph_height_q;
		empty_glyph = (w_eff == '0) || (h_eff == '0);
		wrap = (SIDE_W'(row_q) >= h_eff) || (SIDE_W'(col_q) >= w_eff);
		col_eff = wrap ? '0 : col_q;
		row_eff = wrap ? '0 : row_q;
		x0_pos = POS_W'(cell_x_q) + POS_W'(skip_x_q) + POS_W'(col_eff);
		y_pos  = POS_W'(cell_y_q) + POS_W'(skip_y_q) + POS_W'(row_eff);
		rejected = ((POS_W'(cell_x_q) + $signed(POS_W'(advance_pitch_q))) < 0) ||
			(POS_W'(cell_x_q) >= SCR_W);
		visible = !empty_glyph && !rejected && (y_pos >= 0) && (y_pos < SCR_H);
		row_end = (SIDE_W'(col_eff) + SIDE_W'(2)) >= w_eff;
	end

	// position counters, any register write restarts the glyph
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take && !empty_glyph) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= ((SIDE_W'(row_eff) + SIDE_W'(1)) >= h_eff) ? '0 :
					row_eff + CNT_W'(1);
			end else begin
				col_q <= col_eff + CNT_W'(2);
				row_q <= row_eff;
			end
		end
	end

	// byte stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// byte stage payload
	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= glyph.glyph_byte;
			x0_s1   <= x0_pos[X_W-1:0];
			y_s1    <= y_pos[Y_W-1:0];
			vis_s1  <= visible;
		end
	end

	// left and right pixel lanes
	agb_lane u_lane_l (
		.en        (vis_s1),
		.nibble    (byte_s1[NIB_W-1:0]),
		.x         (x0_s1),
		.pen_color (pen_color_q),
		.pix       (lane_l)
	);

	agb_lane u_lane_r (
		.en        (vis_s1),
		.nibble    (byte_s1[BYTE_W-1:NIB_W]),
		.x         (x0_s1 + X_W'(1)),
		.pen_color (pen_color_q),
		.pix       (lane_r)
	);

	agb_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1_valid (valid_s1),
		.lane_l   (lane_l),
		.lane_r   (lane_r),
		.y        (y_s1),
		.advance  (advance),
		.pixel    (pixel)
	);

	// a register write restarts the glyph
	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> (col_q == '0) && (row_q == '0))
		else $error("counters not cleared by register write");

	// the byte's left pixel always sits on an even column
	a_col_even: assert property (@(posedge clk) disable iff (!arst_n)
		col_q[0] == 1'b0)
		else $error("odd column count");

	// an empty glyph leaves the counters alone
	a_empty_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(take && empty_glyph && !cfg_wr) |=> $stable(col_q) && $stable(row_q))
		else $error("counters moved on empty glyph");

endmodule

### rtl/agb_lane.sv
// one pixel lane: coverage shading of the pen color and column of the write
module agb_lane (
	input  logic                           en,
	input  logic [agb_pkg::NIB_W-1:0]      nibble,
	input  logic signed [agb_pkg::X_W-1:0] x,
	input  logic [agb_pkg::COLOR_W-1:0]    pen_color,
	output agb_pkg::agb_pix_t              pix
);
	import agb_pkg::*;

	logic [CHAN_W-1:0] k;
	logic [CHAN_W-1:0] chan_out [3];

	// coverage weight 2n+1
	assign k = {nibble, 1'b1};

	// per channel ((c+1)*k-1)>>5
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic [CHAN_W:0]   c1;
			logic [2*CHAN_W:0] prod;
			c1 = {1'b0, pen_color[i*CHAN_W +: CHAN_W]} + (CHAN_W+1)'(1);
			prod = (2*CHAN_W+1)'(c1) * (2*CHAN_W+1)'(k) - (2*CHAN_W+1)'(1);
			chan_out[i] = prod[2*CHAN_W-1:CHAN_W];
		end
	end

	assign pix.valid = en && (nibble != '0);
	assign pix.x     = x;
	assign pix.color = {chan_out[2], chan_out[1], chan_out[0]};

endmodule

### rtl/agb_merge.sv
// merges the two lane results into an ordered queue of pixel writes
module agb_merge (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s1_valid,
	input  agb_pkg::agb_pix_t            lane_l,
	input  agb_pkg::agb_pix_t            lane_r,
	input  logic [agb_pkg::Y_W-1:0]      y,
	output logic                         advance,
	agb_pixel_if.source                  pixel
);
	import agb_pkg::*;

	agb_wr_t             queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic [QCNT_W-1:0]   push_k;
	logic                pop;

	// number of writes the current byte adds
	assign push_k  = QCNT_W'(lane_l.valid) + QCNT_W'(lane_r.valid);
	assign advance = s1_valid && ((count_q + push_k) <= QCNT_W'(QUEUE_DEPTH));
	assign pop     = (count_q != '0) && pixel.ready;

	// queue storage, left pixel first
	always_ff @(posedge clk) begin
		if (advance && lane_l.valid) begin
			queue_q[wr_ptr_q] <= '{x: lane_l.x, y: y, color: lane_l.color,
				last: !lane_r.valid};
		end
		if (advance && lane_r.valid) begin
			queue_q[wr_ptr_q + QPTR_W'(lane_l.valid)] <= '{x: lane_r.x, y: y,
				color: lane_r.color, last: 1'b1};
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (advance) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(push_k);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + (advance ? push_k : '0) - QCNT_W'(pop);
		end
	end

	// head of queue drives the port
	assign pixel.valid       = (count_q != '0);
	assign pixel.pixel_x     = queue_q[rd_ptr_q].x;
	assign pixel.pixel_y     = queue_q[rd_ptr_q].y;
	assign pixel.pixel_color = queue_q[rd_ptr_q].color;
	assign pixel.last_write  = queue_q[rd_ptr_q].last;

	// queue never overfills
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("result queue overfilled");

	// stalled output with nothing pushed holds the fill level
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel.valid && !pixel.ready && !(advance && push_k != '0)) |=> $stable(count_q))
		else $error("queue level moved during stall");

	// a byte with two writes only enters when both fit
	a_pair_room: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && push_k == QCNT_W'(2)) |-> count_q <= QCNT_W'(QUEUE_DEPTH - 2))
		else $error("pair pushed without room");

endmodule
